@@ hdl/kbd_pkg.sv @@
package kbd_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned SumW   = 16;
  localparam int unsigned CntW   = 9;
  localparam int unsigned SubW   = 4;
  localparam int unsigned DivW   = 24;
  localparam int unsigned DsrW   = 9;
  localparam int unsigned BitCtW = 5;

  localparam logic [1:0] RegFactor = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegKey    = 2'd2;

  typedef struct packed {
    logic [4:0]  factor;
    logic [10:0] width;
    logic [7:0]  key;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pix_t;

  // one column's running block totals
  typedef struct packed {
    logic [SumW-1:0] sum_r;
    logic [SumW-1:0] sum_g;
    logic [SumW-1:0] sum_b;
    logic [CntW-1:0] cnt;
  } acc_t;

  // finished block handed to the divider side
  typedef struct packed {
    acc_t            acc;
    logic            row_end;
    logic [7:0]      scale;
    logic [DsrW-1:0] fsq;
  } job_t;

  typedef enum logic [1:0] {
    BIdle,
    BDiv,
    BOut
  } back_state_e;

  function automatic logic [DivW-1:0] times255(input logic [DivW-1:0] x);
    return (x << 8) - x;
  endfunction

  function automatic logic [PixW-1:0] sat8(input logic [DivW-1:0] x);
    return (x[DivW-1:PixW] != '0) ? 8'hff : x[PixW-1:0];
  endfunction

endpackage

@@ hdl/keyed_box_downscale_with_alpha.sv @@
// Front end takes a pixel only while not busy and the queue is not full; each accepted pixel
// makes it busy for a read-modify-write of the column RAM. A block result is offered once the
// back end has popped it and finished its divisions; a block with no opaque pixel skips them
// and is given as white with alpha 0. The back end loads each block, runs seven chained
// divisions and then outputs it; a four-entry queue lets the front run ahead of it.
// Reset clears counters, queue, control and config (factor 2, width 1, key 255), not the RAM.
module keyed_box_downscale_with_alpha import kbd_pkg::*; #(
  parameter int unsigned MAX_OUT_WIDTH = 1024,
  parameter int unsigned MAX_FACTOR    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic        m_axis_tlast    // row_end
);

  cfg_t cfg_q;
  pix_t pix;
  job_t job_in, job_out;
  logic push, pop, q_full, q_empty;
  logic [7:0] red, green, blue, alpha;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.factor <= 5'd2;
      cfg_q.width  <= 11'd1;
      cfg_q.key    <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFactor: cfg_q.factor <= cfg_data_i[4:0];
        RegWidth:  cfg_q.width  <= cfg_data_i;
        RegKey:    cfg_q.key    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign pix.red   = s_axis_tdata[7:0];
  assign pix.green = s_axis_tdata[15:8];
  assign pix.blue  = s_axis_tdata[23:16];

  kbd_front #(
    .MaxOutWidth(MAX_OUT_WIDTH),
    .MaxFactor  (MAX_FACTOR)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pix_valid_i(s_axis_tvalid),
    .pix_ready_o(s_axis_tready),
    .pix_i      (pix),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  kbd_queue #(
    .Depth(4)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (q_full),
    .pop_i  (pop),
    .data_o (job_out),
    .empty_o(q_empty)
  );

  kbd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .red_o      (red),
    .green_o    (green),
    .blue_o     (blue),
    .alpha_o    (alpha),
    .row_end_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {alpha, blue, green, red};

endmodule

@@ hdl/kbd_ram.sv @@
module kbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/kbd_queue.sv @@
module kbd_queue import kbd_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_d  = push_i ? bump(wr_q) : wr_q;
    rd_d  = pop_i ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(Depth));

endmodule

@@ hdl/kbd_front.sv @@
module kbd_front import kbd_pkg::*; #(
  parameter int unsigned MaxOutWidth = 1024,
  parameter int unsigned MaxFactor   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic pix_valid_i,
  output logic pix_ready_o,
  input  pix_t pix_i,
  input  logic q_full_i,
  output logic push_o,
  output job_t job_o
);

  localparam int unsigned ColW = (MaxOutWidth > 1) ? $clog2(MaxOutWidth) : 1;
  localparam int unsigned CmpW = 13;

  logic            busy_q;
  pix_t            pix_q;
  logic [ColW-1:0] col_q, col_d, wcol_q;
  logic [SubW-1:0] sc_q, sc_d, sr_q, sr_d;
  logic            first_q, emit_q, rowend_q;
  logic            accept;
  logic [4:0]      f;
  logic [CmpW-1:0] w, col_ext;
  logic            last_sc, last_sr, last_col;
  acc_t            rd_acc, base, acc_new;
  logic [$bits(acc_t)-1:0] rdata;
  logic            opaque;
  logic [9:0]      fsq;

  assign pix_ready_o = !busy_q && !q_full_i;
  assign accept      = pix_valid_i && pix_ready_o;

  always_comb begin
    if (cfg_i.factor == '0) begin
      f = 5'd1;
    end else if (cfg_i.factor > 5'(MaxFactor)) begin
      f = 5'(MaxFactor);
    end else begin
      f = cfg_i.factor;
    end
    if (cfg_i.width == '0) begin
      w = CmpW'(1);
    end else if (CmpW'(cfg_i.width) > CmpW'(MaxOutWidth)) begin
      w = CmpW'(MaxOutWidth);
    end else begin
      w = CmpW'(cfg_i.width);
    end
    col_ext  = CmpW'(col_q);
    last_sc  = 5'(sc_q) >= f - 5'd1;
    last_sr  = 5'(sr_q) >= f - 5'd1;
    last_col = col_ext >= w - CmpW'(1);

    // advance counters in raster order
    sc_d  = sc_q;
    sr_d  = sr_q;
    col_d = col_q;
    if (accept) begin
      if (last_sc) begin
        sc_d = '0;
        if (last_col) begin
          col_d = '0;
          sr_d  = last_sr ? '0 : sr_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end else begin
        sc_d = sc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
      sc_q   <= '0;
      sr_q   <= '0;
    end else begin
      busy_q <= accept;
      col_q  <= col_d;
      sc_q   <= sc_d;
      sr_q   <= sr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q    <= pix_i;
      wcol_q   <= col_q;
      first_q  <= (sr_q == '0) && (sc_q == '0);
      emit_q   <= last_sc && last_sr;
      rowend_q <= last_col;
    end
  end

  kbd_ram #(
    .Width($bits(acc_t)),
    .Depth(MaxOutWidth),
    .AddrW(ColW)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (busy_q),
    .waddr_i(wcol_q),
    .wdata_i(acc_new),
    .re_i   (accept),
    .raddr_i(col_q),
    .rdata_o(rdata)
  );

  always_comb begin
    rd_acc = acc_t'(rdata);
    // first pixel of a block starts the totals over
    base   = first_q ? '0 : rd_acc;
    opaque = !((pix_q.red == cfg_i.key) && (pix_q.green == cfg_i.key) &&
               (pix_q.blue == cfg_i.key));
    acc_new = base;
    if (opaque) begin
      acc_new.sum_r = base.sum_r + SumW'(pix_q.red);
      acc_new.sum_g = base.sum_g + SumW'(pix_q.green);
      acc_new.sum_b = base.sum_b + SumW'(pix_q.blue);
      acc_new.cnt   = base.cnt + 1'b1;
    end
    fsq = {5'd0, f} * {5'd0, f};
    job_o.acc     = acc_new;
    job_o.row_end = rowend_q;
    job_o.scale   = (cfg_i.key == '0) ? 8'd1 : cfg_i.key;
    job_o.fsq     = fsq[DsrW-1:0];
  end

  assign push_o = busy_q && emit_q;

endmodule

@@ hdl/kbd_back.sv @@
module kbd_back import kbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic       row_end_o
);

  back_state_e       state_q, state_d;
  job_t              job_q;
  logic [2:0]        op_q, op_d, op_nx;
  logic [BitCtW-1:0] bit_q, bit_d;
  logic [DsrW:0]     rem_q, rem_d, shifted;
  logic [DivW-1:0]   dq_q, dq_d, ndvd;
  logic [DsrW-1:0]   dsr_q, dsr_d, ndsr;
  logic              ge, load_job;
  logic [7:0]        red_q, green_q, blue_q, alpha_q;
  logic [7:0]        red_d, green_d, blue_d, alpha_d;

  localparam logic [2:0] OpAlpha = 3'd6;

  always_comb begin
    // one restoring step per cycle
    shifted = {rem_q[DsrW-1:0], dq_q[DivW-1]};
    ge      = shifted >= {1'b0, dsr_q};
    rem_d   = ge ? shifted - {1'b0, dsr_q} : shifted;
    dq_d    = {dq_q[DivW-2:0], ge};

    op_nx = op_q + 3'd1;
    case (op_nx)
      3'd2:    begin ndvd = times255(DivW'(job_q.acc.sum_g)); ndsr = DsrW'(job_q.scale); end
      3'd4:    begin ndvd = times255(DivW'(job_q.acc.sum_b)); ndsr = DsrW'(job_q.scale); end
      OpAlpha: begin ndvd = times255(DivW'(job_q.acc.cnt));   ndsr = job_q.fsq; end
      default: begin ndvd = dq_d;                             ndsr = job_q.acc.cnt; end
    endcase

    state_d  = state_q;
    op_d     = op_q;
    bit_d    = bit_q;
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    alpha_d  = alpha_q;
    pop_o    = 1'b0;
    load_job = 1'b0;
    case (state_q)
      BIdle: begin
        if (!q_empty_i) begin
          pop_o    = 1'b1;
          load_job = 1'b1;
          op_d     = '0;
          bit_d    = '0;
          if (job_i.acc.cnt == '0) begin
            red_d   = 8'hff;
            green_d = 8'hff;
            blue_d  = 8'hff;
            alpha_d = 8'h00;
            state_d = BOut;
          end else begin
            state_d = BDiv;
          end
        end
      end
      BDiv: begin
        bit_d = bit_q + 1'b1;
        if (bit_q == BitCtW'(DivW - 1)) begin
          bit_d = '0;
          op_d  = op_nx;
          case (op_q)
            3'd1:    red_d   = sat8(dq_d);
            3'd3:    green_d = sat8(dq_d);
            3'd5:    blue_d  = sat8(dq_d);
            OpAlpha: alpha_d = sat8(dq_d);
            default: ;
          endcase
          if (op_q == OpAlpha) begin
            state_d = BOut;
          end
        end
      end
      BOut: begin
        if (out_ready_i) begin
          state_d = BIdle;
        end
      end
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BIdle;
      op_q    <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    alpha_q <= alpha_d;
    if (load_job) begin
      job_q <= job_i;
      rem_q <= '0;
      dq_q  <= times255(DivW'(job_i.acc.sum_r));
      dsr_q <= DsrW'(job_i.scale);
    end else if (state_q == BDiv) begin
      if (bit_q == BitCtW'(DivW - 1)) begin
        // chain the next division
        rem_q <= '0;
        dq_q  <= ndvd;
        dsr_q <= ndsr;
      end else begin
        rem_q <= rem_d;
        dq_q  <= dq_d;
      end
    end
  end

  assign out_valid_o = (state_q == BOut);
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;
  assign row_end_o   = job_q.row_end;

endmodule
